// ===== rtl/prv_pkg.sv =====
// Package for the packet record validator.
// Holds the item types, the controller command struct, error codes and limits.
// No dependencies.
package prv_pkg;

    localparam int TRACK_SLOTS_DEF = 4;
    localparam int GEN_SLOTS_DEF   = 8;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 27;
    localparam int PAYLOAD_LIMIT_W = 27;
    localparam int EXTRA_LIMIT_W   = 25;

    localparam logic [CFG_IDX_W-1:0] REG_MAX_PAYLOAD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_EXTRA   = 2'd1;

    localparam logic [PAYLOAD_LIMIT_W-1:0] PAYLOAD_LIMIT_RST = 27'd131072;
    localparam logic [EXTRA_LIMIT_W-1:0]   EXTRA_LIMIT_RST   = 25'd1048576;

    localparam logic [31:0] KIND_VIDEO = 32'd1;
    localparam logic [31:0] KIND_AUDIO = 32'd2;

    localparam logic OP_CONFIG = 1'b0;
    localparam logic OP_PACKET = 1'b1;

    localparam logic [3:0] ERR_OK      = 4'd0;
    localparam logic [3:0] ERR_FIELD   = 4'd1;
    localparam logic [3:0] ERR_FULL    = 4'd2;
    localparam logic [3:0] ERR_DUP     = 4'd3;
    localparam logic [3:0] ERR_NOTRACK = 4'd4;
    localparam logic [3:0] ERR_KIND    = 4'd5;
    localparam logic [3:0] ERR_NOGEN   = 4'd6;
    localparam logic [3:0] ERR_TB      = 4'd7;
    localparam logic [3:0] ERR_SIZE    = 4'd8;

    typedef struct packed {
        logic               operation;
        logic               publish_track;
        logic [31:0]        track_id;
        logic [31:0]        generation_id;
        logic [31:0]        track_kind;
        logic signed [31:0] timebase_num;
        logic signed [31:0] timebase_den;
        logic [31:0]        extra_len;
        logic [31:0]        packet_flags;
        logic [31:0]        payload_len;
        logic signed [63:0] duration;
    } rec_in_t;

    typedef struct packed {
        logic        accepted;
        logic [3:0]  error_cause;
        logic [31:0] group_number;
        logic        is_video;
    } rec_out_t;

    typedef struct packed {
        logic load;
        logic match;
        logic decide;
        logic commit;
    } prv_cmd_t;

endpackage

// ===== rtl/prv_ctrl.sv =====
// Controller for the packet record validator.
// Steps each item through load, match, decide and commit; uses prv_pkg.
module prv_ctrl
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    output logic             done,
    output prv_pkg::prv_cmd_t cmd
);
    import prv_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_MATCH  = 4'b0010,
        ST_DECIDE = 4'b0100,
        ST_REPORT = 4'b1000
    } prv_state_t;

    prv_state_t state_reg;
    prv_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_MATCH;
                end
            end
            ST_MATCH:  state_next = ST_DECIDE;
            ST_DECIDE: state_next = ST_REPORT;
            ST_REPORT: state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    assign busy       = (state_reg != ST_IDLE);
    assign done       = (state_reg == ST_REPORT);
    assign cmd.load   = (state_reg == ST_IDLE) && start;
    assign cmd.match  = (state_reg == ST_MATCH);
    assign cmd.decide = (state_reg == ST_DECIDE);
    assign cmd.commit = (state_reg == ST_REPORT);

endmodule

// ===== rtl/prv_datapath.sv =====
// Datapath for the packet record validator.
// Holds limits, track and generation tables, matchers and the result register; uses prv_pkg.
module prv_datapath
#(
    parameter int TRACK_SLOTS = prv_pkg::TRACK_SLOTS_DEF,
    parameter int GEN_SLOTS   = prv_pkg::GEN_SLOTS_DEF
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  prv_pkg::prv_cmd_t                cmd,
    input  prv_pkg::rec_in_t                 request,
    input  logic                             cfg_write,
    input  logic [prv_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [prv_pkg::CFG_DATA_W-1:0]   cfg_data,
    output prv_pkg::rec_out_t                result
);
    import prv_pkg::*;

    localparam int TCNT_W = $clog2(TRACK_SLOTS + 1);
    localparam int GCNT_W = $clog2(GEN_SLOTS + 1);
    localparam int TIDX_W = (TRACK_SLOTS > 1) ? $clog2(TRACK_SLOTS) : 1;
    localparam int GIDX_W = (GEN_SLOTS > 1) ? $clog2(GEN_SLOTS) : 1;

    logic [PAYLOAD_LIMIT_W-1:0] max_payload_reg;
    logic [EXTRA_LIMIT_W-1:0]   max_extra_reg;

    logic [31:0] trk_id_reg    [TRACK_SLOTS];
    logic        trk_video_reg [TRACK_SLOTS];
    logic [31:0] gen_trk_reg   [GEN_SLOTS];
    logic [31:0] gen_gen_reg   [GEN_SLOTS];
    logic [30:0] gen_num_reg   [GEN_SLOTS];
    logic [30:0] gen_den_reg   [GEN_SLOTS];

    logic [TCNT_W-1:0] track_count_reg;
    logic [GCNT_W-1:0] gen_count_reg;
    logic [31:0]       group_counter_reg;
    logic              keyframe_seen_reg;

    rec_in_t in_reg;

    logic [TRACK_SLOTS-1:0] trk_hit_reg;
    logic [GEN_SLOTS-1:0]   gen_hit_reg;
    logic                   cfg_bad_reg;
    logic                   extra_over_reg;
    logic                   size_over_reg;
    logic                   pkt_bad_reg;
    logic                   gen_full_reg;
    logic                   trk_full_reg;

    logic              ok_reg;
    logic              cfg_commit_reg;
    logic              key_adv_reg;
    rec_out_t          result_reg;

    logic [TIDX_W-1:0] t_idx;
    logic [GIDX_W-1:0] g_idx;
    logic              trk_found;
    logic              gen_found;
    logic              trk_video;
    logic              kind_video;
    logic              tb_mismatch;
    logic              key_hit;
    logic [31:0]       group_new;
    logic [3:0]        cause;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_payload_reg <= PAYLOAD_LIMIT_RST;
            max_extra_reg   <= EXTRA_LIMIT_RST;
        end
        else if (cfg_write)
        begin
            if (cfg_index == REG_MAX_PAYLOAD)
            begin
                max_payload_reg <= cfg_data[PAYLOAD_LIMIT_W-1:0];
            end
            else if (cfg_index == REG_MAX_EXTRA)
            begin
                max_extra_reg <= cfg_data[EXTRA_LIMIT_W-1:0];
            end
        end
    end

    // match stage
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            in_reg <= request;
        end
        if (cmd.match)
        begin
            for (int i = 0; i < TRACK_SLOTS; i++)
            begin
                trk_hit_reg[i] <= (TCNT_W'(i) < track_count_reg) &&
                                  (trk_id_reg[i] == in_reg.track_id);
            end
            for (int j = 0; j < GEN_SLOTS; j++)
            begin
                gen_hit_reg[j] <= (GCNT_W'(j) < gen_count_reg) &&
                                  (gen_trk_reg[j] == in_reg.track_id) &&
                                  (gen_gen_reg[j] == in_reg.generation_id);
            end
            cfg_bad_reg    <= (in_reg.track_id == 32'd0) ||
                              (in_reg.generation_id == 32'd0) ||
                              (in_reg.timebase_num <= 32'sd0) ||
                              (in_reg.timebase_den <= 32'sd0) ||
                              ((in_reg.track_kind != KIND_VIDEO) &&
                               (in_reg.track_kind != KIND_AUDIO));
            extra_over_reg <= in_reg.extra_len > {7'd0, max_extra_reg};
            size_over_reg  <= in_reg.payload_len > {5'd0, max_payload_reg};
            pkt_bad_reg    <= in_reg.duration[63] || (in_reg.packet_flags[31:1] != 31'd0);
            gen_full_reg   <= gen_count_reg >= GCNT_W'(GEN_SLOTS);
            trk_full_reg   <= track_count_reg >= TCNT_W'(TRACK_SLOTS);
        end
    end

    // first matching entry wins
    always_comb
    begin
        t_idx = '0;
        for (int i = TRACK_SLOTS - 1; i >= 0; i--)
        begin
            if (trk_hit_reg[i])
            begin
                t_idx = TIDX_W'(i);
            end
        end
        g_idx = '0;
        for (int j = GEN_SLOTS - 1; j >= 0; j--)
        begin
            if (gen_hit_reg[j])
            begin
                g_idx = GIDX_W'(j);
            end
        end
    end

    assign trk_found   = |trk_hit_reg;
    assign gen_found   = |gen_hit_reg;
    assign trk_video   = trk_video_reg[t_idx];
    assign kind_video  = (in_reg.track_kind == KIND_VIDEO);
    assign tb_mismatch = ($unsigned(in_reg.timebase_num) != {1'b0, gen_num_reg[g_idx]}) ||
                         ($unsigned(in_reg.timebase_den) != {1'b0, gen_den_reg[g_idx]});
    assign key_hit     = trk_video && in_reg.packet_flags[0];
    assign group_new   = (key_hit && keyframe_seen_reg) ? group_counter_reg + 32'd1
                                                        : group_counter_reg;

    always_comb
    begin
        if (in_reg.operation == OP_CONFIG)
        begin
            priority if (cfg_bad_reg)                  cause = ERR_FIELD;
            else if (extra_over_reg)                   cause = ERR_SIZE;
            else if (gen_full_reg)                     cause = ERR_FULL;
            else if (in_reg.publish_track && trk_found) cause = ERR_DUP;
            else if (in_reg.publish_track && trk_full_reg) cause = ERR_FULL;
            else if (!in_reg.publish_track && !trk_found) cause = ERR_NOTRACK;
            else if (!in_reg.publish_track && (trk_video != kind_video)) cause = ERR_KIND;
            else                                       cause = ERR_OK;
        end
        else
        begin
            priority if (!trk_found)  cause = ERR_NOTRACK;
            else if (!gen_found)      cause = ERR_NOGEN;
            else if (tb_mismatch)     cause = ERR_TB;
            else if (size_over_reg)   cause = ERR_SIZE;
            else if (pkt_bad_reg)     cause = ERR_FIELD;
            else                      cause = ERR_OK;
        end
    end

    // decide stage
    always_ff @(posedge clk)
    begin
        if (cmd.decide)
        begin
            ok_reg                  <= (cause == ERR_OK);
            cfg_commit_reg          <= (cause == ERR_OK) && (in_reg.operation == OP_CONFIG);
            key_adv_reg             <= (cause == ERR_OK) && (in_reg.operation == OP_PACKET) &&
                                       key_hit;
            result_reg.accepted     <= (cause == ERR_OK);
            result_reg.error_cause  <= cause;
            result_reg.group_number <= ((cause == ERR_OK) && (in_reg.operation == OP_PACKET))
                                       ? group_new : 32'd0;
            result_reg.is_video     <= (cause == ERR_OK) &&
                                       ((in_reg.operation == OP_CONFIG) ? kind_video
                                                                        : trk_video);
        end
    end

    // commit stage: tables
    always_ff @(posedge clk)
    begin
        if (cmd.commit && cfg_commit_reg)
        begin
            if (in_reg.publish_track)
            begin
                trk_id_reg[track_count_reg[TIDX_W-1:0]]    <= in_reg.track_id;
                trk_video_reg[track_count_reg[TIDX_W-1:0]] <= kind_video;
            end
            gen_trk_reg[gen_count_reg[GIDX_W-1:0]] <= in_reg.track_id;
            gen_gen_reg[gen_count_reg[GIDX_W-1:0]] <= in_reg.generation_id;
            gen_num_reg[gen_count_reg[GIDX_W-1:0]] <= in_reg.timebase_num[30:0];
            gen_den_reg[gen_count_reg[GIDX_W-1:0]] <= in_reg.timebase_den[30:0];
        end
    end

    // commit stage: counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            track_count_reg   <= '0;
            gen_count_reg     <= '0;
            group_counter_reg <= 32'd0;
            keyframe_seen_reg <= 1'b0;
        end
        else if (cmd.commit && ok_reg)
        begin
            if (cfg_commit_reg)
            begin
                gen_count_reg <= gen_count_reg + GCNT_W'(1);
                if (in_reg.publish_track)
                begin
                    track_count_reg <= track_count_reg + TCNT_W'(1);
                end
            end
            if (key_adv_reg)
            begin
                group_counter_reg <= result_reg.group_number;
                keyframe_seen_reg <= 1'b1;
            end
        end
    end

    assign result = result_reg;

endmodule

// ===== rtl/packet_record_validator.sv =====
// Top level of the packet record validator.
// Joins prv_ctrl and prv_datapath; uses prv_pkg.
//
//   channel   | handshake                 | payload
//   ----------+---------------------------+---------------------------
//   request   | start high, busy low      | request  (rec_in_t)
//   result    | done strobe, one cycle    | result   (rec_out_t)
//   config    | cfg_valid and cfg_ready   | cfg_index, cfg_data
//
// An item steps through accept, match against both tables, decide and report.
// done is high in the report state, after the match and decide states; the next item can be
// accepted at the edge that ends the cycle after done. Table matches run in parallel.
// Reset restores the limits and clears counts and keyframe state, not table entries.
// The receiver cannot stall: done marks each result in its done cycle only; result holds until the next decide.
module packet_record_validator
#(
    parameter int TRACK_SLOTS = prv_pkg::TRACK_SLOTS_DEF,
    parameter int GEN_SLOTS   = prv_pkg::GEN_SLOTS_DEF
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  prv_pkg::rec_in_t               request,
    output logic                           done,
    output prv_pkg::rec_out_t              result,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [prv_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [prv_pkg::CFG_DATA_W-1:0] cfg_data
);
    import prv_pkg::*;

    prv_cmd_t cmd;

    assign cfg_ready = 1'b1;

    prv_ctrl u_ctrl
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .done  (done),
        .cmd   (cmd)
    );

    prv_datapath
    #(
        .TRACK_SLOTS (TRACK_SLOTS),
        .GEN_SLOTS   (GEN_SLOTS)
    )
    u_datapath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .request   (request),
        .cfg_write (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .result    (result)
    );

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("item accepted without going busy");

    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy ##1 !busy)
        else $error("done outside an item or busy held after it");

    a_cause_ok: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (result.accepted == (result.error_cause == ERR_OK)))
        else $error("accepted flag disagrees with error cause");

    a_reject_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !result.accepted) |-> ((result.group_number == 32'd0) && !result.is_video))
        else $error("rejected item carries group or video flag");

endmodule
